// ----- design/lossless_image_predictor_unit_assert.svh -----
// Assertion macros shared by the lossless image predictor.
`ifndef LOSSLESS_IMAGE_PREDICTOR_UNIT_ASSERT_SVH
`define LOSSLESS_IMAGE_PREDICTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lip_pkg.sv -----
// ----------------------------------------------------------------------------
// lip_pkg
// Shared constants, register codes and types of the lossless image predictor.
// ----------------------------------------------------------------------------
package lip_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int CFG_W        = 13;
    localparam int WCMP_W       = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = 12;
    localparam int HCMP_W       = 13;
    localparam int SAMPLE_W     = 10;
    localparam int PIX_W        = 8;
    localparam int CALC_W       = 12;
    localparam int MODE_W       = 4;
    localparam int CFG_IDX_W    = 4;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd3;

    localparam logic [MODE_W-1:0] PM_LEFT       = 4'd1;
    localparam logic [MODE_W-1:0] PM_ABOVE      = 4'd2;
    localparam logic [MODE_W-1:0] PM_DIAG       = 4'd3;
    localparam logic [MODE_W-1:0] PM_PLANE      = 4'd4;
    localparam logic [MODE_W-1:0] PM_LEFT_GRAD  = 4'd5;
    localparam logic [MODE_W-1:0] PM_ABOVE_GRAD = 4'd6;
    localparam logic [MODE_W-1:0] PM_AVERAGE    = 4'd7;
    localparam logic [MODE_W-1:0] PM_MED        = 4'd8;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RST   = PM_MED;
    localparam logic [CFG_W-1:0]  WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              dir;
        logic [CFG_W-1:0]  width;
        logic [CFG_W-1:0]  height;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [COL_W-1:0]    col;
        logic                col_zero;
        logic                row_zero;
        logic                eor;
        logic                eof;
    } t_item;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_q_stat;

    typedef struct packed {
        logic s1_valid;
        logic wr_en;
    } t_back_stat;

endpackage

// ----- design/lossless_image_predictor_unit.sv -----
// ----------------------------------------------------------------------------
// lossless_image_predictor_unit
// Lossless JPEG / median edge predictor over a raster pixel stream.
// ----------------------------------------------------------------------------
// The unit sustains one sample per clock unless the output stalls; an accepted
// sample passes the queue, the read stage and the output register. The
// rate is set by the line buffer, a block RAM with one read and one write port
// used once each per sample; the left and upper-left neighbours live in
// registers and a same-column write is forwarded. The line buffer needs no
// clearing after reset. Configuration must only be written while the unit is
// idle; frame-edge flags mark the last pixel of each row and of the frame.
`include "lossless_image_predictor_unit_assert.svh"

module lossless_image_predictor_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lip_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lip_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [lip_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [lip_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                 o_end_of_row,
    output logic                                 o_end_of_frame
);

    lip_pkg::t_cfg       r_cfg;
    lip_pkg::t_item      front_item, q_head;
    lip_pkg::t_q_stat    q_stat;
    lip_pkg::t_back_stat b_stat;
    logic                push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= lip_pkg::MODE_RST;
            r_cfg.dir    <= lip_pkg::DIR_ENCODE;
            r_cfg.width  <= lip_pkg::WIDTH_RST;
            r_cfg.height <= lip_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lip_pkg::CFG_MODE:   r_cfg.mode   <= i_cfg_data[lip_pkg::MODE_W-1:0];
                lip_pkg::CFG_DIR:    r_cfg.dir    <= i_cfg_data[0];
                lip_pkg::CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                lip_pkg::CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .i_sample_in (i_sample_in),
        .o_stall     (o_stall),
        .i_q_full    (q_stat.full),
        .o_push      (push),
        .o_item      (front_item)
    );

    lip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    lip_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (q_head),
        .i_q_empty      (q_stat.empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_out   (o_sample_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame),
        .o_stat         (b_stat)
    );

    `LIP_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, q_stat.count <= lip_pkg::QUEUE_DEPTH, "queue overfilled")
    `LIP_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, i_valid && !o_stall, !q_stat.empty, "accepted transaction not queued")
    `LIP_ASSERT_NOW(a_eof_is_eor, i_clk, i_rst_n, o_valid && o_end_of_frame, o_end_of_row, "end of frame without end of row")
    `LIP_ASSERT_NEXT(a_write_gives_result, i_clk, i_rst_n, b_stat.wr_en, o_valid, "line buffer write without result")

endmodule

// ----- design/lip_ram.sv -----
// ----------------------------------------------------------------------------
// lip_ram
// Generic simple dual-port RAM with a registered, read-first read port.
// ----------------------------------------------------------------------------
module lip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lip_front.sv -----
// ----------------------------------------------------------------------------
// lip_front
// Accepts samples, tracks the raster position and tags each transaction with
// its frame-edge flags before it enters the queue.
// ----------------------------------------------------------------------------
module lip_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lip_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    input  logic signed [lip_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_stall,
    input  logic                                i_q_full,
    output logic                                o_push,
    output lip_pkg::t_item                      o_item
);

    logic [lip_pkg::COL_W-1:0]  r_col, n_col;
    logic [lip_pkg::ROW_W-1:0]  r_row, n_row;
    logic [lip_pkg::WCMP_W-1:0] fw, width_eff;
    logic [lip_pkg::HCMP_W-1:0] fh, height_eff;
    logic                       eor, eof;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Out-of-range sizes are clamped to the nearest legal value.
    always_comb begin
        fw = lip_pkg::WCMP_W'(i_cfg.width);
        if (fw == '0) begin
            width_eff = lip_pkg::WCMP_W'(1);
        end else if (fw > lip_pkg::WCMP_W'(lip_pkg::MAX_WIDTH)) begin
            width_eff = lip_pkg::WCMP_W'(lip_pkg::MAX_WIDTH);
        end else begin
            width_eff = fw;
        end
        fh = lip_pkg::HCMP_W'(i_cfg.height);
        if (fh == '0) begin
            height_eff = lip_pkg::HCMP_W'(1);
        end else if (fh > lip_pkg::HCMP_W'(lip_pkg::HEIGHT_LIMIT)) begin
            height_eff = lip_pkg::HCMP_W'(lip_pkg::HEIGHT_LIMIT);
        end else begin
            height_eff = fh;
        end
    end

    assign eor = (lip_pkg::WCMP_W'(r_col) + lip_pkg::WCMP_W'(1)) >= width_eff;
    assign eof = eor && ((lip_pkg::HCMP_W'(r_row) + lip_pkg::HCMP_W'(1)) >= height_eff);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (eor) begin
                n_col = '0;
                n_row = eof ? '0 : r_row + lip_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + lip_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_item.sample   = i_sample_in;
        o_item.col      = r_col;
        o_item.col_zero = (r_col == '0);
        o_item.row_zero = (r_row == '0);
        o_item.eor      = eor;
        o_item.eof      = eof;
    end

endmodule

// ----- design/lip_queue.sv -----
// ----------------------------------------------------------------------------
// lip_queue
// Short FIFO of classified transactions between the front and the back.
// ----------------------------------------------------------------------------
module lip_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lip_pkg::t_item   i_item,
    input  logic             i_pop,
    output lip_pkg::t_item   o_head,
    output lip_pkg::t_q_stat o_stat
);

    lip_pkg::t_item              r_mem [lip_pkg::QUEUE_DEPTH];
    logic [lip_pkg::QPTR_W-1:0]  r_wptr, r_rptr;
    logic [lip_pkg::QCNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + lip_pkg::QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - lip_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + lip_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + lip_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_head       = r_mem[r_rptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == lip_pkg::QCNT_W'(lip_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ----- design/lip_back.sv -----
// ----------------------------------------------------------------------------
// lip_back
// Reads the line buffer, forms the prediction, writes the pixel back and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module lip_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lip_pkg::t_cfg                       i_cfg,
    input  lip_pkg::t_item                      i_head,
    input  logic                                i_q_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [lip_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_end_of_row,
    output logic                                o_end_of_frame,
    output lip_pkg::t_back_stat                 o_stat
);

    localparam int CW = lip_pkg::CALC_W;
    localparam int PW = lip_pkg::PIX_W;

    logic                   adv, wr_en;
    logic                   r_s1_valid;
    lip_pkg::t_item         r_s1_item;
    logic                   r_s1_fwd;
    logic [PW-1:0]          r_s1_fwd_pix;
    logic [PW-1:0]          r_left, r_upper;
    logic [PW-1:0]          ram_rdata, above, pixel;
    logic                   r_out_valid;
    logic [lip_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                   r_out_eor, r_out_eof;

    logic [CW-1:0] a, b, c, hi, lo, pred, d, dsum, half, sample_x, result;

    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && !i_q_empty;
    assign wr_en = adv && r_s1_valid;

    lip_ram #(
        .WIDTH (PW),
        .DEPTH (lip_pkg::MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_item.col),
        .i_wdata (pixel),
        .i_re    (o_pop),
        .i_raddr (i_head.col),
        .o_rdata (ram_rdata)
    );

    // A read issued in the same cycle as the write to that column sees the
    // old contents, so the freshly written pixel is forwarded instead.
    assign above = r_s1_fwd ? r_s1_fwd_pix : ram_rdata;

    always_comb begin
        a = r_s1_item.col_zero ? '0 : CW'(r_left);
        b = r_s1_item.row_zero ? '0 : CW'(above);
        c = (r_s1_item.col_zero || r_s1_item.row_zero) ? '0 : CW'(r_upper);
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;

        case (i_cfg.mode)
            lip_pkg::PM_LEFT_GRAD: d = b - c;
            lip_pkg::PM_ABOVE_GRAD: d = a - c;
            default: d = b - c;
        endcase
        // Halving rounds toward zero, so negative values are bumped by one
        // before the arithmetic shift.
        dsum = d + CW'(d[CW-1]);
        half = {dsum[CW-1], dsum[CW-1:1]};

        case (i_cfg.mode)
            lip_pkg::PM_LEFT:       pred = a;
            lip_pkg::PM_ABOVE:      pred = b;
            lip_pkg::PM_DIAG:       pred = c;
            lip_pkg::PM_PLANE:      pred = a + b - c;
            lip_pkg::PM_LEFT_GRAD:  pred = a + half;
            lip_pkg::PM_ABOVE_GRAD: pred = b + half;
            lip_pkg::PM_AVERAGE:    pred = (a + b) >> 1;
            default: begin
                if (c >= hi) begin
                    pred = lo;
                end else if (c <= lo) begin
                    pred = hi;
                end else begin
                    pred = a + b - c;
                end
            end
        endcase

        sample_x = {{(CW - lip_pkg::SAMPLE_W){r_s1_item.sample[lip_pkg::SAMPLE_W-1]}},
                    r_s1_item.sample};
        if (i_cfg.dir == lip_pkg::DIR_DECODE) begin
            pixel  = PW'(sample_x + pred);
            result = CW'(pixel);
        end else begin
            pixel  = r_s1_item.sample[PW-1:0];
            result = CW'(pixel) - pred;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_upper     <= '0;
        end else if (adv) begin
            r_s1_valid  <= o_pop;
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_left  <= pixel;
                r_upper <= above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (o_pop) begin
                r_s1_item    <= i_head;
                r_s1_fwd     <= wr_en && (i_head.col == r_s1_item.col);
                r_s1_fwd_pix <= pixel;
            end
            if (r_s1_valid) begin
                r_out_sample <= result[lip_pkg::SAMPLE_W-1:0];
                r_out_eor    <= r_s1_item.eor;
                r_out_eof    <= r_s1_item.eof;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sample_out    = r_out_sample;
    assign o_end_of_row    = r_out_eor;
    assign o_end_of_frame  = r_out_eof;
    assign o_stat.s1_valid = r_s1_valid;
    assign o_stat.wr_en    = wr_en;

endmodule

// ----- bench/lossless_image_predictor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// lossless_image_predictor_unit_tb
// Self-checking bench for the lossless image predictor. A short scripted
// sequence walks every predictor, both directions, the frame-size extremes
// and out-of-range samples, then random phases reconfigure the unit between
// runs of pixels. Each output is checked against a behavioural line-buffer
// predictor in the bench or a scripted value, under random back-pressure.
// ----------------------------------------------------------------------------
module lossless_image_predictor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int CALM_ITEMS    = 200;
    localparam int SETTLE_CYCLES = 3;
    localparam int HOLD_CYCLES   = 48;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int CFG_MAX       = (1 << lip_pkg::CFG_W) - 1;

    localparam logic [lip_pkg::MODE_W-1:0] MODE_BELOW_RANGE = 4'd0;
    localparam logic [lip_pkg::MODE_W-1:0] MODE_ABOVE_RANGE = 4'd15;

    typedef struct packed {
        logic [lip_pkg::SAMPLE_W-1:0] sample;
        logic                         eor;
        logic                         eof;
    } t_result;

    typedef enum logic {ROW_SAMPLE, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [lip_pkg::CFG_IDX_W-1:0] idx;
        logic [lip_pkg::CFG_W-1:0]     value;
        logic [lip_pkg::SAMPLE_W-1:0]  smp;
        logic                          typed;
        t_result                       want;
    } t_script_row;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_cfg_we       = 1'b0;
    logic [lip_pkg::CFG_IDX_W-1:0]       i_cfg_idx      = '0;
    logic [lip_pkg::CFG_W-1:0]           i_cfg_data     = '0;
    logic                                i_valid        = 1'b0;
    logic                                o_stall;
    logic signed [lip_pkg::SAMPLE_W-1:0] i_sample_in    = '0;
    logic                                o_valid;
    logic                                i_stall        = 1'b0;
    logic signed [lip_pkg::SAMPLE_W-1:0] o_sample_out;
    logic                                o_end_of_row;
    logic                                o_end_of_frame;

    // Bench copy of the configuration and of the unit's state.
    logic [lip_pkg::MODE_W-1:0] cfg_mode   = lip_pkg::MODE_RST;
    logic                       cfg_dir    = lip_pkg::DIR_ENCODE;
    logic [lip_pkg::CFG_W-1:0]  cfg_width  = lip_pkg::WIDTH_RST;
    logic [lip_pkg::CFG_W-1:0]  cfg_height = lip_pkg::HEIGHT_RST;
    logic [lip_pkg::PIX_W-1:0]  line_buf [lip_pkg::MAX_WIDTH];
    logic [lip_pkg::PIX_W-1:0]  left_pix    = '0;
    logic [lip_pkg::PIX_W-1:0]  up_left_pix = '0;
    int                         col_pos     = 0;
    int                         row_pos     = 0;
    int                         cols_seen   = 0;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      cycle_count    = 0;

    logic    idle_on    = 1'b1;
    logic    calm       = 1'b0;
    int      hold_asks  = 0;
    int      hold_done  = 0;
    int      hold_left  = 0;
    int      burst_left = 0;

    logic    out_fire = 1'b0;
    t_result out_seen = '0;

    lossless_image_predictor_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_in    (i_sample_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_out   (o_sample_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Predicts one output transaction and advances the line buffer, the
    // neighbours and the raster position.
    function automatic t_result next_pixel_result(input logic [lip_pkg::SAMPLE_W-1:0] raw);
        t_result                   r;
        int                        w_lim, h_lim, a, b, c, p, hi, lo, res;
        logic [lip_pkg::PIX_W-1:0] above, pixel;
        w_lim = (cfg_width == 0) ? 1
                : ((cfg_width > lip_pkg::MAX_WIDTH) ? lip_pkg::MAX_WIDTH : int'(cfg_width));
        h_lim = (cfg_height == 0) ? 1
                : ((cfg_height > lip_pkg::HEIGHT_LIMIT) ? lip_pkg::HEIGHT_LIMIT
                                                        : int'(cfg_height));
        above = line_buf[col_pos];
        a = (col_pos > 0) ? int'(left_pix) : 0;
        b = (row_pos > 0) ? int'(above) : 0;
        c = (row_pos > 0 && col_pos > 0) ? int'(up_left_pix) : 0;
        case (cfg_mode)
            lip_pkg::PM_LEFT:       p = a;
            lip_pkg::PM_ABOVE:      p = b;
            lip_pkg::PM_DIAG:       p = c;
            lip_pkg::PM_PLANE:      p = a + b - c;
            lip_pkg::PM_LEFT_GRAD:  p = a + (b - c) / 2;
            lip_pkg::PM_ABOVE_GRAD: p = b + (a - c) / 2;
            lip_pkg::PM_AVERAGE:    p = (a + b) / 2;
            default: begin
                hi = (a > b) ? a : b;
                lo = (a > b) ? b : a;
                if (c >= hi) p = lo;
                else if (c <= lo) p = hi;
                else p = a + b - c;
            end
        endcase
        if (cfg_dir == lip_pkg::DIR_ENCODE) begin
            pixel = raw[lip_pkg::PIX_W-1:0];
            res   = int'(pixel) - p;
        end else begin
            pixel = lip_pkg::PIX_W'(int'($signed(raw)) + p);
            res   = int'(pixel);
        end
        r.sample = lip_pkg::SAMPLE_W'(res);
        r.eor    = (col_pos + 1 >= w_lim);
        r.eof    = r.eor && (row_pos + 1 >= h_lim);
        up_left_pix       = above;
        left_pix          = pixel;
        line_buf[col_pos] = pixel;
        if (col_pos + 1 > cols_seen) cols_seen = col_pos + 1;
        if (r.eor) begin
            col_pos = 0;
            row_pos = r.eof ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return r;
    endfunction

    function automatic t_script_row reg_row(input logic [lip_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [lip_pkg::CFG_W-1:0] value);
        return '{ROW_REG, idx, value, '0, 1'b0, '0};
    endfunction

    function automatic t_script_row pix_row(input logic [lip_pkg::SAMPLE_W-1:0] smp);
        return '{ROW_SAMPLE, '0, '0, smp, 1'b0, '0};
    endfunction

    function automatic t_script_row pix_row_chk(input logic [lip_pkg::SAMPLE_W-1:0] smp,
                                                input logic [lip_pkg::SAMPLE_W-1:0] out,
                                                input logic eor, input logic eof);
        return '{ROW_SAMPLE, '0, '0, smp, 1'b1, '{out, eor, eof}};
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        mismatch_count++;
    endtask

    // Offers one sample and waits for its transaction. Valid stays high on
    // return so that back-to-back samples need no second assignment.
    task automatic send_sample(input logic [lip_pkg::SAMPLE_W-1:0] raw, input logic typed,
                               input t_result typed_res);
        t_result predicted;
        logic    go;
        if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= raw;
        do begin
            @(negedge i_clk);
            go = !o_stall;
            @(posedge i_clk);
        end while (!go);
        predicted = next_pixel_result(raw);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lip_pkg::CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lip_pkg::CFG_MODE:   cfg_mode   = value[lip_pkg::MODE_W-1:0];
            lip_pkg::CFG_DIR:    cfg_dir    = value[0];
            lip_pkg::CFG_WIDTH:  cfg_width  = value;
            lip_pkg::CFG_HEIGHT: cfg_height = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Forces the raster position back to the top of a frame with a
    // one-pixel frame.
    task automatic restart_frame();
        settle();
        write_reg(lip_pkg::CFG_WIDTH, lip_pkg::CFG_W'(1));
        write_reg(lip_pkg::CFG_HEIGHT, lip_pkg::CFG_W'(1));
        send_sample(lip_pkg::SAMPLE_W'($urandom_range(0, 1023)), 1'b0, '0);
        settle();
    endtask

    // Receiver: random stall bursts, plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_done != hold_asks) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left--;
            i_stall <= 1'b1;
        end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Outputs are sampled mid-cycle; the transaction happens at the next edge.
    always @(negedge i_clk) begin
        out_fire        = i_rst_n && o_valid && !i_stall;
        out_seen.sample = o_sample_out;
        out_seen.eor    = o_end_of_row;
        out_seen.eof    = o_end_of_frame;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (out_fire) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("output transaction with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (out_seen.sample !== want.sample)
                    flag_mismatch($sformatf("sample_out got %0d, expected %0d",
                                            $signed(out_seen.sample), $signed(want.sample)));
                if (out_seen.eor !== want.eor)
                    flag_mismatch($sformatf("end_of_row got %b, expected %b",
                                            out_seen.eor, want.eor));
                if (out_seen.eof !== want.eof)
                    flag_mismatch($sformatf("end_of_frame got %b, expected %b",
                                            out_seen.eof, want.eof));
            end
            results_seen++;
        end
    end

    initial begin
        t_script_row                  script [$];
        int                           normal_items, phase, n, pause_at, w_eff;
        logic [lip_pkg::CFG_W-1:0]    w, h;
        logic [lip_pkg::SAMPLE_W-1:0] raw;

        foreach (line_buf[k]) line_buf[k] = '0;

        // Reset settings: median predictor, encoding, 640 x 480.
        script = '{
            pix_row_chk(10'd255, 10'd255, 1'b0, 1'b0),
            reg_row(lip_pkg::CFG_WIDTH, lip_pkg::CFG_W'(2)),
            reg_row(lip_pkg::CFG_HEIGHT, lip_pkg::CFG_W'(2)),
            pix_row_chk(10'd0, -10'sd255, 1'b1, 1'b0),
            pix_row_chk(10'd255, 10'd0, 1'b0, 1'b0),
            pix_row_chk(10'd0, 10'd0, 1'b1, 1'b1),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(lip_pkg::PM_LEFT)),
            // Pixels outside 0..255 keep only their low byte.
            pix_row_chk(10'd510, 10'd254, 1'b0, 1'b0),
            pix_row_chk(-10'sd1, 10'd1, 1'b1, 1'b0),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(lip_pkg::PM_ABOVE)),
            pix_row_chk(10'd0, -10'sd254, 1'b0, 1'b0),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(lip_pkg::PM_DIAG)),
            pix_row_chk(10'd100, -10'sd154, 1'b1, 1'b1),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(lip_pkg::PM_PLANE)),
            pix_row(10'd7),
            pix_row(10'd200),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(lip_pkg::PM_LEFT_GRAD)),
            pix_row(10'd9),
            pix_row(10'd3),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(lip_pkg::PM_ABOVE_GRAD)),
            pix_row(10'd250),
            pix_row(10'd0),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(lip_pkg::PM_AVERAGE)),
            pix_row(10'd1),
            pix_row(10'd255),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(MODE_BELOW_RANGE)),
            pix_row(10'd128),
            pix_row(10'd3),
            reg_row(lip_pkg::CFG_MODE, lip_pkg::CFG_W'(MODE_ABOVE_RANGE)),
            reg_row(lip_pkg::CFG_DIR, lip_pkg::CFG_W'(lip_pkg::DIR_DECODE)),
            pix_row(10'h200),
            pix_row(10'h1FF),
            // Zero width and height act as one: every pixel ends the frame.
            reg_row(lip_pkg::CFG_WIDTH, lip_pkg::CFG_W'(0)),
            reg_row(lip_pkg::CFG_HEIGHT, lip_pkg::CFG_W'(0)),
            pix_row_chk(10'h1FF, 10'd255, 1'b1, 1'b1),
            pix_row_chk(10'h200, 10'd0, 1'b1, 1'b1),
            reg_row(lip_pkg::CFG_DIR, lip_pkg::CFG_W'(lip_pkg::DIR_ENCODE))
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            if (script[k].kind == ROW_REG) begin
                settle();
                write_reg(script[k].idx, script[k].value);
            end else begin
                send_sample(script[k].smp, script[k].typed, script[k].want);
            end
        end

        normal_items = 0;
        phase        = 0;
        while (normal_items < RANDOM_ITEMS) begin
            settle();
            pause_at = -1;
            idle_on  = ($urandom_range(0, 3) != 0);
            calm     = (normal_items >= RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 1) == 1)
                write_reg(lip_pkg::CFG_MODE,
                          ($urandom_range(0, 3) == 0)
                          ? lip_pkg::CFG_W'($urandom_range(0, 15))
                          : lip_pkg::CFG_W'($urandom_range(lip_pkg::PM_LEFT, lip_pkg::PM_MED)));
            if ($urandom_range(0, 1) == 1)
                write_reg(lip_pkg::CFG_DIR, lip_pkg::CFG_W'($urandom_range(0, 1)));

            if (phase == 2 || phase == 6) begin
                // Oversized settings from the top of a frame: the widest row,
                // then the tallest column.
                restart_frame();
                if (phase == 2) begin
                    write_reg(lip_pkg::CFG_WIDTH, lip_pkg::CFG_W'(CFG_MAX));
                    write_reg(lip_pkg::CFG_HEIGHT, lip_pkg::CFG_W'(2));
                end else begin
                    write_reg(lip_pkg::CFG_WIDTH, lip_pkg::CFG_W'(1));
                    write_reg(lip_pkg::CFG_HEIGHT, lip_pkg::CFG_W'(CFG_MAX));
                end
                n = $urandom_range(100, 200);
            end else begin
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 9))
                        0:       w = '0;
                        1:       w = lip_pkg::CFG_W'($urandom_range(lip_pkg::MAX_WIDTH + 1,
                                                                    CFG_MAX));
                        2:       w = lip_pkg::CFG_W'(lip_pkg::MAX_WIDTH);
                        3, 4:    w = lip_pkg::CFG_W'($urandom_range(17, 64));
                        default: w = lip_pkg::CFG_W'($urandom_range(1, 16));
                    endcase
                    w_eff = (w == 0) ? 1
                            : ((w > lip_pkg::MAX_WIDTH) ? lip_pkg::MAX_WIDTH : int'(w));
                    // Below the first row only columns already stored may be read.
                    if (row_pos != 0 && w_eff > cols_seen) w = lip_pkg::CFG_W'(cols_seen);
                    write_reg(lip_pkg::CFG_WIDTH, w);
                end
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 7))
                        0:       h = '0;
                        1:       h = lip_pkg::CFG_W'($urandom_range(lip_pkg::HEIGHT_LIMIT,
                                                                    CFG_MAX));
                        default: h = lip_pkg::CFG_W'($urandom_range(1, 8));
                    endcase
                    write_reg(lip_pkg::CFG_HEIGHT, h);
                end
                n = $urandom_range(20, 120);
                if (phase == 1) begin
                    // Long receiver hold-off while samples keep coming.
                    idle_on = 1'b0;
                    hold_asks++;
                end
                if (phase == 4) pause_at = n / 2;
            end

            for (int k = 0; k < n; k++) begin
                if (k == pause_at) settle();
                if (cfg_dir == lip_pkg::DIR_ENCODE)
                    raw = ($urandom_range(0, 6) == 0)
                          ? lip_pkg::SAMPLE_W'($urandom_range(0, 1023))
                          : lip_pkg::SAMPLE_W'($urandom_range(0, 255));
                else
                    raw = ($urandom_range(0, 1) == 0)
                          ? lip_pkg::SAMPLE_W'($urandom_range(0, 32) - 16)
                          : lip_pkg::SAMPLE_W'($urandom_range(0, 1023));
                send_sample(raw, 1'b0, '0);
            end
            normal_items += n;
            phase++;
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
